// File: sv/dual_incremental_pid_motor_drive_defines.svh
// Assertion macros shared by the motor drive checker
`ifndef DUAL_INCREMENTAL_PID_MOTOR_DRIVE_DEFINES_SVH
`define DUAL_INCREMENTAL_PID_MOTOR_DRIVE_DEFINES_SVH

// Same-cycle implication, silenced during reset
`define DPMD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dpmd check failed");

// Next-cycle implication, silenced during reset
`define DPMD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dpmd check failed");

`endif

// File: sv/dpmd_pkg.sv
// Shared types, widths and constants of the dual PID motor drive
package dpmd_pkg;

  // Field widths
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned GAIN_W      = 24;
  localparam int unsigned DUTY_W      = 16;
  localparam int unsigned ERR_W       = 18;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned PID_ACC_W   = 34;
  localparam int unsigned DRV_W       = PID_ACC_W - FRAC_BITS;
  localparam int unsigned ACC_W       = 46;

  // Window status widths cover the largest supported window (16)
  localparam int unsigned SUM_MAX_W   = 21;
  localparam int unsigned FILL_MAX_W  = 5;

  // Shared multiplier operands
  localparam int unsigned MUL_A_W     = 26;
  localparam int unsigned MUL_B_W     = 21;
  localparam int unsigned PROD_W      = MUL_A_W + MUL_B_W;

  // Reciprocal division by the fill count
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP_W     = 25;
  localparam int unsigned AVG_MAG_W   = COUNT_W + 1;
  localparam int unsigned RECIP_DEPTH = 17;

  // ceil(2^24 / f); exact floor for magnitudes below 2^20 and f up to 16
  localparam logic [RECIP_W-1:0] RECIP_TABLE [RECIP_DEPTH] = '{
    25'd0,       25'd16777216, 25'd8388608, 25'd5592406,
    25'd4194304, 25'd3355444,  25'd2796203, 25'd2396746,
    25'd2097152, 25'd1864136,  25'd1677722, 25'd1525202,
    25'd1398102, 25'd1290556,  25'd1198373, 25'd1118482,
    25'd1048576
  };

  // Drive limit and its Q.16 form
  localparam int unsigned DRIVE_LIMIT = 49000;
  localparam logic signed [ACC_W-1:0] DRIVE_LIM_Q = ACC_W'(DRIVE_LIMIT) << FRAC_BITS;
  localparam logic [DUTY_W-1:0] FULL_SCALE_RST = 16'd50000;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_P    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_I    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_D    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 3'd6;

  // Sequencer steps
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_AVG   = 9'b000000010,
    ST_ERR   = 9'b000000100,
    ST_P     = 9'b000001000,
    ST_I     = 9'b000010000,
    ST_D     = 9'b000100000,
    ST_ADD   = 9'b001000000,
    ST_CLAMP = 9'b010000000,
    ST_OUT   = 9'b100000000
  } step_e;

  typedef struct packed {
    step_e step;
    logic  chan;
    logic  push;
    logic  load_out;
  } ctrl_t;

  typedef struct packed {
    logic signed [SUM_MAX_W-1:0] sum_left;
    logic signed [SUM_MAX_W-1:0] sum_right;
    logic [FILL_MAX_W-1:0]       fill;
  } win_stat_t;

endpackage

// File: sv/dpmd_ifs.sv
// Channel interfaces: input tick, output drive and configuration write
interface dpmd_in_if import dpmd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COUNT_W-1:0] target_left;
  logic signed [COUNT_W-1:0] target_right;
  logic signed [COUNT_W-1:0] count_left;
  logic signed [COUNT_W-1:0] count_right;

  modport source (output valid, target_left, target_right, count_left, count_right,
                  input ready);
  modport sink (input valid, target_left, target_right, count_left, count_right,
                output ready);
endinterface

interface dpmd_out_if import dpmd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              dir_first;
  logic [DUTY_W-1:0] duty_first;
  logic              dir_second;
  logic [DUTY_W-1:0] duty_second;

  modport source (output valid, dir_first, duty_first, dir_second, duty_second,
                  input ready);
  modport sink (input valid, dir_first, duty_first, dir_second, duty_second,
                output ready);
endinterface

interface dpmd_cfg_if import dpmd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [GAIN_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/dpmd_window.sv
// Encoder count windows with running sums, write slot and fill count
module dpmd_window import dpmd_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic signed [COUNT_W-1:0] count_left_i,
  input  logic signed [COUNT_W-1:0] count_right_i,
  output win_stat_t                 stat_o
);

  localparam int unsigned SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int unsigned SUM_W  = COUNT_W + FILL_W;

  logic signed [COUNT_W-1:0] win_l_q [WINDOW_LEN];
  logic signed [COUNT_W-1:0] win_r_q [WINDOW_LEN];
  logic [SLOT_W-1:0]         slot_q, slot_d;
  logic [FILL_W-1:0]         fill_q, fill_d;
  logic signed [SUM_W-1:0]   sum_l_q, sum_l_d;
  logic signed [SUM_W-1:0]   sum_r_q, sum_r_d;

  // Replace the oldest sample in the running sums, advance slot and fill
  always_comb begin
    sum_l_d = sum_l_q + SUM_W'(count_left_i) - SUM_W'(win_l_q[slot_q]);
    sum_r_d = sum_r_q + SUM_W'(count_right_i) - SUM_W'(win_r_q[slot_q]);
    slot_d  = (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + 1'b1;
    fill_d  = (fill_q == FILL_W'(WINDOW_LEN)) ? fill_q : fill_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_l_q[i] <= '0;
        win_r_q[i] <= '0;
      end
      slot_q  <= '0;
      fill_q  <= '0;
      sum_l_q <= '0;
      sum_r_q <= '0;
    end else if (push_i) begin
      win_l_q[slot_q] <= count_left_i;
      win_r_q[slot_q] <= count_right_i;
      slot_q          <= slot_d;
      fill_q          <= fill_d;
      sum_l_q         <= sum_l_d;
      sum_r_q         <= sum_r_d;
    end
  end

  assign stat_o.sum_left  = SUM_MAX_W'(sum_l_q);
  assign stat_o.sum_right = SUM_MAX_W'(sum_r_q);
  assign stat_o.fill      = FILL_MAX_W'(fill_q);

endmodule

// File: sv/dpmd_mul.sv
// Shared signed multiplier with registered product
module dpmd_mul import dpmd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [PROD_W-1:0]  prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  // Capture the product when a step issues a multiply
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

// File: sv/dpmd_seq.sv
// Step sequencer: walks both channels through the shared multiplier
module dpmd_seq import dpmd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  out_ready_i,
  output logic  out_valid_o,
  output ctrl_t ctrl_o
);

  step_e step_q, step_d;
  logic  chan_q, chan_d;
  logic  out_valid_q, out_valid_d;
  logic  out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Advance through the steps; left channel first, then right
  always_comb begin
    step_d = step_q;
    chan_d = chan_q;
    unique case (step_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          step_d = ST_AVG;
          chan_d = 1'b0;
        end
      end
      ST_AVG:   step_d = ST_ERR;
      ST_ERR:   step_d = ST_P;
      ST_P:     step_d = ST_I;
      ST_I:     step_d = ST_D;
      ST_D:     step_d = ST_ADD;
      ST_ADD:   step_d = ST_CLAMP;
      ST_CLAMP: begin
        if (chan_q) begin
          step_d = ST_OUT;
        end else begin
          step_d = ST_AVG;
          chan_d = 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          step_d = ST_IDLE;
        end
      end
      default:  step_d = ST_IDLE;
    endcase
  end

  assign in_ready_o      = (step_q == ST_IDLE);
  assign ctrl_o.step     = step_q;
  assign ctrl_o.chan     = chan_q;
  assign ctrl_o.push     = in_valid_i && in_ready_o;
  assign ctrl_o.load_out = (step_q == ST_OUT) && out_free;

  // Hold the result until taken
  assign out_valid_d = ctrl_o.load_out || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_IDLE;
      chan_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      chan_q      <= chan_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: sv/dual_incremental_pid_motor_drive.sv
// One transaction at a time: a new input is taken only once the result has been loaded.
// Each channel takes seven steps through the single shared multiplier (average, error,
// P, I, D, final add, clamp), channels in turn, then the output register is loaded.
// Reset (async, active low) clears windows, fill count, error history and accumulators,
// sets gains to zero and full scale to 50000; no clearing pass is needed.
module dual_incremental_pid_motor_drive import dpmd_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dpmd_in_if.sink           in_i,
  dpmd_out_if.source        out_o,
  dpmd_cfg_if.sink          cfg_i
);

  localparam int unsigned DRV_EXT_W = DRV_W + 1;

  typedef struct packed {
    logic              dir;
    logic [DUTY_W-1:0] duty;
  } drv_t;

  ctrl_t     ctrl;
  win_stat_t stat;

  logic signed [GAIN_W-1:0]    kp_q [2];
  logic signed [GAIN_W-1:0]    ki_q [2];
  logic signed [GAIN_W-1:0]    kd_q [2];
  logic [DUTY_W-1:0]           fs_q;
  logic signed [ERR_W-1:0]     e1_q [2];
  logic signed [ERR_W-1:0]     e2_q [2];
  logic signed [PID_ACC_W-1:0] acc_q [2];
  logic signed [COUNT_W-1:0]   tl_q, tr_q;
  logic signed [ERR_W-1:0]     err_q, err_d;
  logic signed [ACC_W-1:0]     wacc_q, wacc_clamp;

  logic signed [SUM_MAX_W-1:0] sel_sum;
  logic                        sel_neg;
  logic signed [MUL_B_W-1:0]   sum_mag;
  logic signed [ERR_W-1:0]     avg_mag, avg;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic                        mul_en;
  logic signed [PROD_W-1:0]    prod;

  logic signed [DRV_W-1:0]     v_left, v_right, v_second;
  drv_t                        drv_first, drv_second;
  logic                        dir_first_q, dir_second_q;
  logic [DUTY_W-1:0]           duty_first_q, duty_second_q;

  // Q.16 accumulator to integer, truncating toward zero
  function automatic logic signed [DRV_W-1:0] to_drive(input logic signed [PID_ACC_W-1:0] a);
    logic signed [DRV_W-1:0] hi;
    logic                    round_up;
    hi       = a[PID_ACC_W-1:FRAC_BITS];
    round_up = a[PID_ACC_W-1] && (a[FRAC_BITS-1:0] != '0);
    return hi + DRV_W'(round_up);
  endfunction

  // Direction and duty; reverse duty is full scale plus value, floored at zero
  function automatic drv_t map_drive(input logic signed [DRV_W-1:0] v,
                                     input logic [DUTY_W-1:0] fs);
    drv_t                        r;
    logic signed [DRV_EXT_W-1:0] d;
    d = DRV_EXT_W'($signed({1'b0, fs})) + DRV_EXT_W'(v);
    if (!v[DRV_W-1]) begin
      r.dir  = 1'b0;
      r.duty = v[DUTY_W-1:0];
    end else begin
      r.dir  = 1'b1;
      r.duty = d[DRV_EXT_W-1] ? '0 : d[DUTY_W-1:0];
    end
    return r;
  endfunction

  dpmd_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .ctrl_o      (ctrl)
  );

  dpmd_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (ctrl.push),
    .count_left_i  (in_i.count_left),
    .count_right_i (in_i.count_right),
    .stat_o        (stat)
  );

  dpmd_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Select the channel's window sum and its magnitude
  assign sel_sum = ctrl.chan ? stat.sum_right : stat.sum_left;
  assign sel_neg = sel_sum[SUM_MAX_W-1];
  assign sum_mag = sel_neg ? MUL_B_W'(-sel_sum) : MUL_B_W'(sel_sum);

  // Average from the reciprocal product, then error against the target
  assign avg_mag = ERR_W'($signed({1'b0, prod[RECIP_SHIFT +: AVG_MAG_W]}));
  assign avg     = sel_neg ? -avg_mag : avg_mag;
  assign err_d   = ERR_W'(ctrl.chan ? tr_q : tl_q) - avg;

  // Route operands into the shared multiplier
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    unique case (ctrl.step) inside
      ST_AVG: begin
        mul_a  = MUL_A_W'($signed({1'b0, RECIP_TABLE[FILL_MAX_W'(stat.fill)]}));
        mul_b  = sum_mag;
        mul_en = 1'b1;
      end
      ST_P: begin
        mul_a  = MUL_A_W'(kp_q[ctrl.chan]);
        mul_b  = MUL_B_W'(err_q) - MUL_B_W'(e1_q[ctrl.chan]);
        mul_en = 1'b1;
      end
      ST_I: begin
        mul_a  = MUL_A_W'(ki_q[ctrl.chan]);
        mul_b  = MUL_B_W'(err_q);
        mul_en = 1'b1;
      end
      ST_D: begin
        mul_a  = MUL_A_W'(kd_q[ctrl.chan]);
        mul_b  = MUL_B_W'(err_q) - (MUL_B_W'(e1_q[ctrl.chan]) <<< 1)
                 + MUL_B_W'(e2_q[ctrl.chan]);
        mul_en = 1'b1;
      end
      ST_IDLE, ST_ERR, ST_ADD, ST_CLAMP, ST_OUT: begin
        mul_en = 1'b0;
      end
      default: mul_en = 1'b0;
    endcase
  end

  // Clamp the working sum to the drive limit
  always_comb begin
    if (wacc_q > DRIVE_LIM_Q) begin
      wacc_clamp = DRIVE_LIM_Q;
    end else if (wacc_q < -DRIVE_LIM_Q) begin
      wacc_clamp = -DRIVE_LIM_Q;
    end else begin
      wacc_clamp = wacc_q;
    end
  end

  // Latch targets and build up the working sum
  always_ff @(posedge clk_i) begin
    if (ctrl.push) begin
      tl_q <= in_i.target_left;
      tr_q <= in_i.target_right;
    end
    if (ctrl.step == ST_ERR) begin
      err_q <= err_d;
    end
    unique case (ctrl.step) inside
      ST_P:               wacc_q <= ACC_W'(acc_q[ctrl.chan]);
      ST_I, ST_D, ST_ADD: wacc_q <= wacc_q + ACC_W'(prod);
      default:            wacc_q <= wacc_q;
    endcase
  end

  // Configuration registers and per-channel PID state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2; c++) begin
        kp_q[c]  <= '0;
        ki_q[c]  <= '0;
        kd_q[c]  <= '0;
        e1_q[c]  <= '0;
        e2_q[c]  <= '0;
        acc_q[c] <= '0;
      end
      fs_q <= FULL_SCALE_RST;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          REG_LEFT_P:     kp_q[0] <= cfg_i.data;
          REG_LEFT_I:     ki_q[0] <= cfg_i.data;
          REG_LEFT_D:     kd_q[0] <= cfg_i.data;
          REG_RIGHT_P:    kp_q[1] <= cfg_i.data;
          REG_RIGHT_I:    ki_q[1] <= cfg_i.data;
          REG_RIGHT_D:    kd_q[1] <= cfg_i.data;
          REG_FULL_SCALE: fs_q    <= cfg_i.data[DUTY_W-1:0];
          default:        fs_q    <= fs_q;
        endcase
      end
      if (ctrl.step == ST_CLAMP) begin
        acc_q[ctrl.chan] <= PID_ACC_W'(wacc_clamp);
        e2_q[ctrl.chan]  <= e1_q[ctrl.chan];
        e1_q[ctrl.chan]  <= err_q;
      end
    end
  end

  assign cfg_i.ready = 1'b1;

  // Cross the outputs: right drives the first motor, negated left the second
  assign v_left     = to_drive(acc_q[0]);
  assign v_right    = to_drive(acc_q[1]);
  assign v_second   = -v_left;
  assign drv_first  = map_drive(v_right, fs_q);
  assign drv_second = map_drive(v_second, fs_q);

  always_ff @(posedge clk_i) begin
    if (ctrl.load_out) begin
      dir_first_q   <= drv_first.dir;
      duty_first_q  <= drv_first.duty;
      dir_second_q  <= drv_second.dir;
      duty_second_q <= drv_second.duty;
    end
  end

  assign out_o.dir_first   = dir_first_q;
  assign out_o.duty_first  = duty_first_q;
  assign out_o.dir_second  = dir_second_q;
  assign out_o.duty_second = duty_second_q;

endmodule

// File: sv/dpmd_checker.sv
// Port-level checks of the motor drive, bound to the top level
`include "dual_incremental_pid_motor_drive_defines.svh"

module dpmd_checker import dpmd_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              dir_first,
  input logic [DUTY_W-1:0] duty_first,
  input logic              dir_second,
  input logic [DUTY_W-1:0] duty_second
);

  // A stalled result holds its payload
  `DPMD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(duty_first) && $stable(duty_second) && $stable(dir_first) && $stable(dir_second))

  // One transaction at a time: busy right after acceptance
  `DPMD_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid && in_ready, !in_ready)

  // A result never appears the cycle after acceptance
  `DPMD_ASSERT_NXT(a_no_instant_result, clk_i, rst_ni, in_valid && in_ready, !$rose(out_valid))

  // Forward duty stays within the drive limit
  `DPMD_ASSERT_IMP(a_fwd_limit, clk_i, rst_ni, out_valid && !dir_first && !dir_second, (duty_first <= DUTY_W'(DRIVE_LIMIT)) && (duty_second <= DUTY_W'(DRIVE_LIMIT)))

endmodule

bind dual_incremental_pid_motor_drive dpmd_checker u_dpmd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .dir_first   (out_o.dir_first),
  .duty_first  (out_o.duty_first),
  .dir_second  (out_o.dir_second),
  .duty_second (out_o.duty_second)
);
